// File: rtl/core/binary_min_heap_queue_macros.svh
// Assertion macros for the binary min-heap queue.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define BMHQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent follows an antecedent in the same cycle.
`define BMHQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bmhq_pkg.sv
// Shared types and codes for the binary min-heap queue.
// No dependencies; imported by the level cell and the top level.
`default_nettype none

package bmhq_pkg;

  localparam int unsigned POS_W = 16;

  typedef logic signed [31:0] key_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_SIFT,
    S_ROOT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    key_t             key;
  } slot_t;

  localparam slot_t SLOT_NONE = '{valid: 1'b0, pos: '0, key: '0};

endpackage

`default_nettype wire

// File: rtl/core/bmhq_cell.sv
// One heap level: the keys of that level and the compare step of a sift.
// Depends on bmhq_pkg for the slot and key types.
`default_nettype none

module bmhq_cell #(
  parameter int unsigned LEVEL = 1,
  parameter int unsigned CW    = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CW-1:0]                count_i,
  input  bmhq_pkg::slot_t              dn_i,
  input  bmhq_pkg::slot_t              up_i,
  input  bmhq_pkg::slot_t              wr_from_above_i,
  input  bmhq_pkg::slot_t              wr_from_below_i,
  input  logic [bmhq_pkg::POS_W-1:0]   rd_pos_i,
  output bmhq_pkg::slot_t              dn_o,
  output bmhq_pkg::slot_t              up_o,
  output bmhq_pkg::slot_t              wr_above_o,
  output bmhq_pkg::slot_t              wr_below_o,
  output logic                         done_o,
  output bmhq_pkg::key_t               rd_data_o
);
  import bmhq_pkg::*;

  localparam int unsigned AW    = (LEVEL > 0) ? LEVEL : 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [CW-1:0] LVL_BASE = CW'(1) << LEVEL;

  key_t             mem_q [DEPTH];
  key_t             a_q;
  key_t             b_q;
  logic             pend_dn_q;
  logic             pend_up_q;
  logic [POS_W-1:0] pend_pos_q;
  key_t             pend_key_q;

  logic [POS_W:0]   pos_x2;
  logic [POS_W-1:0] pos_half;
  logic [AW-1:0]    addr_l;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    addr_a;
  slot_t            wr;

  logic [CW-1:0]    off;
  logic [CW-1:0]    lidx;
  logic [CW-1:0]    ridx;
  logic             take_l;
  logic             take_r;
  key_t             best_key;
  logic             swap_up;

  assign pos_x2   = {dn_i.pos, 1'b0};
  assign pos_half = up_i.pos >> 1;
  assign addr_l   = pos_x2[AW-1:0];
  assign addr_r   = addr_l | AW'(1);

  always_comb begin
    if (dn_i.valid) begin
      addr_a = addr_l;
    end else if (up_i.valid) begin
      addr_a = pos_half[AW-1:0];
    end else begin
      addr_a = rd_pos_i[AW-1:0];
    end
  end

  assign wr = wr_from_below_i.valid ? wr_from_below_i : wr_from_above_i;

  always_ff @(posedge clk_i) begin
    if (wr.valid) begin
      mem_q[wr.pos[AW-1:0]] <= wr.key;
    end
    a_q <= mem_q[addr_a];
    b_q <= mem_q[addr_r];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_dn_q <= 1'b0;
      pend_up_q <= 1'b0;
    end else begin
      pend_dn_q <= dn_i.valid;
      pend_up_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_pos_q <= dn_i.valid ? dn_i.pos : up_i.pos;
    pend_key_q <= dn_i.valid ? dn_i.key : up_i.key;
  end

  assign off      = CW'({pend_pos_q, 1'b0});
  assign lidx     = LVL_BASE + off;
  assign ridx     = lidx | CW'(1);
  assign take_l   = (lidx <= count_i) && (a_q < pend_key_q);
  assign best_key = take_l ? a_q : pend_key_q;
  assign take_r   = (ridx <= count_i) && (b_q < best_key);
  assign swap_up  = pend_key_q < a_q;

  always_comb begin
    dn_o       = SLOT_NONE;
    up_o       = SLOT_NONE;
    wr_above_o = SLOT_NONE;
    wr_below_o = SLOT_NONE;
    done_o     = 1'b0;
    if (pend_dn_q) begin
      wr_above_o.valid = 1'b1;
      wr_above_o.pos   = pend_pos_q;
      wr_above_o.key   = take_r ? b_q : best_key;
      if (take_l || take_r) begin
        dn_o.valid = 1'b1;
        dn_o.pos   = POS_W'({pend_pos_q, take_r});
        dn_o.key   = pend_key_q;
      end else begin
        done_o = 1'b1;
      end
    end
    if (pend_up_q) begin
      wr_below_o.valid = 1'b1;
      wr_below_o.pos   = pend_pos_q;
      wr_below_o.key   = swap_up ? a_q : pend_key_q;
      if (swap_up) begin
        up_o.valid = 1'b1;
        up_o.pos   = pend_pos_q >> 1;
        up_o.key   = pend_key_q;
      end else begin
        done_o = 1'b1;
      end
    end
  end

  assign rd_data_o = a_q;

endmodule

`default_nettype wire

// File: rtl/core/binary_min_heap_queue.sv
// Top level of the binary min-heap queue: control and a chain of level cells.
// Depends on bmhq_pkg, bmhq_cell and binary_min_heap_queue_macros.svh.
//
//   channel   direction   signals
//   request   in          in_valid_i, in_ready_o, func_i, key_in_i
//   result    out         out_valid_o, out_ready_i, status_o, removed_key_o,
//                         min_key_o, entry_count_o
//
// From the accepting cycle to its result, an insert goes through the sift, root and done
// states and a delete through load, fetch, sift, root and done; a refused request or an
// insert into an empty heap goes straight to root, and a delete of the last key skips the
// sift. The sift walks at most one less level than the heap has levels.
// Reset empties the heap at once; the key store needs no clearing.
// One request is worked on at a time; the next is taken while a result waits.
`default_nettype none

module binary_min_heap_queue #(
  parameter int unsigned HEAP_CAPACITY = 127
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic signed [31:0]    key_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic signed [31:0]    removed_key_o,
  output logic signed [31:0]    min_key_o,
  output logic [6:0]            entry_count_o
);
  import bmhq_pkg::*;

  localparam int unsigned LEVELS = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned CW     = LEVELS;
  localparam int unsigned PW     = LEVELS - 1;
  localparam int unsigned LW     = $clog2(LEVELS + 1);
  localparam int unsigned LSEL   = $clog2(LEVELS);

  state_e        state_q;
  state_e        state_d;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;
  logic [LW-1:0] nlev_q;
  logic [LW-1:0] nlev_d;
  logic [PW-1:0] npos_q;
  logic [PW-1:0] npos_d;
  status_e       status_q;
  key_t          removed_q;

  logic          out_valid_q;
  status_e       out_status_q;
  key_t          out_removed_q;
  key_t          out_min_q;
  logic [CW-1:0] out_count_q;

  logic          accept;
  logic          is_delete;
  logic          full;
  logic          empty;
  logic          out_free;
  logic          out_load;
  logic [PW:0]   span_up;
  logic [PW:0]   span_dn;
  logic [LW-1:0] inj_cell;
  slot_t         inj_root;
  slot_t         inj_up;
  slot_t         inj_dn;
  logic          done_any;

  slot_t         dn_in     [LEVELS];
  slot_t         up_in     [LEVELS];
  slot_t         above_in  [LEVELS];
  slot_t         below_in  [LEVELS];
  slot_t         dn_out    [LEVELS];
  slot_t         up_out    [LEVELS];
  slot_t         above_out [LEVELS];
  slot_t         below_out [LEVELS];
  logic          cell_done [LEVELS];
  key_t          rd_data   [LEVELS];
  logic [LEVELS-1:0] done_v;
  logic [LEVELS-1:0] tok_v;

  assign is_delete = (func_i == FUNC_DELETE);
  assign full      = (count_q == CW'(HEAP_CAPACITY));
  assign empty     = (count_q == '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign span_up   = (PW + 1)'(1) << nlev_q;
  assign span_dn   = (PW + 1)'(1) << (nlev_q - LW'(1));
  assign inj_cell  = nlev_q - LW'(1);
  assign done_any  = |done_v;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (is_delete) begin
            state_d = empty ? S_ROOT : S_LOAD;
          end else if (full || nlev_q == '0) begin
            state_d = S_ROOT;
          end else begin
            state_d = S_SIFT;
          end
        end
      end
      S_LOAD:  state_d = S_FETCH;
      S_FETCH: state_d = empty ? S_ROOT : S_SIFT;
      S_SIFT: begin
        if (done_any) begin
          state_d = S_ROOT;
        end
      end
      S_ROOT:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    accept     = in_valid_i && in_ready_o;
    out_load   = (state_q == S_DONE) && out_free;

    inj_root       = SLOT_NONE;
    inj_root.valid = accept && !is_delete && !full && (nlev_q == '0);
    inj_root.key   = key_in_i;

    inj_up       = SLOT_NONE;
    inj_up.valid = accept && !is_delete && !full && (nlev_q != '0);
    inj_up.pos   = POS_W'(npos_q);
    inj_up.key   = key_in_i;

    inj_dn       = SLOT_NONE;
    inj_dn.valid = (state_q == S_FETCH) && !empty;
    inj_dn.key   = rd_data[nlev_q[LSEL-1:0]];
  end

  always_comb begin
    count_d = count_q;
    nlev_d  = nlev_q;
    npos_d  = npos_q;
    if (accept && !is_delete && !full) begin
      count_d = count_q + CW'(1);
      if (npos_q == PW'(span_up - (PW + 1)'(1))) begin
        nlev_d = nlev_q + LW'(1);
        npos_d = '0;
      end else begin
        npos_d = npos_q + PW'(1);
      end
    end else if (accept && is_delete && !empty) begin
      count_d = count_q - CW'(1);
      if (npos_q == '0) begin
        nlev_d = nlev_q - LW'(1);
        npos_d = PW'(span_dn - (PW + 1)'(1));
      end else begin
        npos_d = npos_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      nlev_q      <= '0;
      npos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      nlev_q  <= nlev_d;
      npos_q  <= npos_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= '0;
      if (is_delete && empty) begin
        status_q <= STAT_EMPTY;
      end else if (!is_delete && full) begin
        status_q <= STAT_FULL;
      end else begin
        status_q <= STAT_OK;
      end
    end else if (state_q == S_FETCH) begin
      removed_q <= rd_data[0];
    end
    if (out_load) begin
      out_status_q  <= status_q;
      out_removed_q <= removed_q;
      out_min_q     <= empty ? '0 : rd_data[0];
      out_count_q   <= count_q;
    end
  end

  for (genvar j = 0; j < LEVELS; j++) begin : g_cell
    if (j == 0) begin : g_root
      assign dn_in[j]    = SLOT_NONE;
      assign above_in[j] = up_out[j].valid ? up_out[j] : inj_root;
    end else begin : g_inner
      assign dn_in[j]    = (j == 1 && inj_dn.valid) ? inj_dn : dn_out[j-1];
      assign above_in[j] = below_out[j-1];
    end
    if (j == LEVELS - 1) begin : g_leaf
      assign up_in[j]    = SLOT_NONE;
      assign below_in[j] = dn_out[j];
      assign done_v[j]   = cell_done[j] || dn_out[j].valid ||
                           ((j == 0) && up_out[j].valid);
    end else begin : g_chain
      assign up_in[j]    = (inj_up.valid && inj_cell == LW'(j)) ? inj_up : up_out[j+1];
      assign below_in[j] = above_out[j+1];
      assign done_v[j]   = cell_done[j] || ((j == 0) && up_out[j].valid);
    end
    assign tok_v[j] = dn_in[j].valid || up_in[j].valid;

    bmhq_cell #(
      .LEVEL (j),
      .CW    (CW)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .count_i         (count_q),
      .dn_i            (dn_in[j]),
      .up_i            (up_in[j]),
      .wr_from_above_i (above_in[j]),
      .wr_from_below_i (below_in[j]),
      .rd_pos_i        ((j == 0) ? POS_W'(0) : POS_W'(npos_q)),
      .dn_o            (dn_out[j]),
      .up_o            (up_out[j]),
      .wr_above_o      (above_out[j]),
      .wr_below_o      (below_out[j]),
      .done_o          (cell_done[j]),
      .rd_data_o       (rd_data[j])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign removed_key_o = out_removed_q;
  assign min_key_o     = out_min_q;
  assign entry_count_o = 7'(out_count_q);

  `include "binary_min_heap_queue_macros.svh"

  `BMHQ_ASSERT(a_count_range, count_q <= CW'(HEAP_CAPACITY), "Heap count above capacity.")
  `BMHQ_ASSERT(a_one_token, $onehot0(tok_v), "More than one level is sifting.")
  `BMHQ_ASSERT_IMPL(a_done_in_sift, done_any, state_q == S_SIFT, "Sift ended outside sift.")
  `BMHQ_ASSERT_IMPL(a_result_src, $rose(out_valid_q), $past(state_q == S_DONE), "Stray result.")

endmodule

`default_nettype wire

// File: test/binary_min_heap_queue_checker.sv
// Checker for the binary min-heap queue: watches the request and result channels.
// Keeps its own heap to predict each result and compares field by field.
// Depends on bmhq_pkg.
module binary_min_heap_queue_checker
  import bmhq_pkg::*;
#(
  parameter int unsigned HEAP_CAPACITY = 127
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic              func_i,
  input  logic signed [31:0] key_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [1:0]        status_i,
  input  logic signed [31:0] removed_key_i,
  input  logic signed [31:0] min_key_i,
  input  logic [6:0]        entry_count_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                full_hits_o,
  output int                empty_hits_o
);

  typedef struct {
    status_e    status;
    key_t       removed_key;
    key_t       min_key;
    logic [6:0] entry_count;
  } heap_outcome_t;

  key_t          heap_keys [0:HEAP_CAPACITY];
  int            heap_size = 0;
  heap_outcome_t outcome_q [$];
  int            fails = 0;
  int            checked = 0;
  int            full_hits = 0;
  int            empty_hits = 0;

  function automatic void swap_keys(input int unsigned a, input int unsigned b);
    key_t held;
    held = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = held;
  endfunction

  function automatic heap_outcome_t apply_request(input func_e op, input key_t k);
    heap_outcome_t r;
    int unsigned   pos;
    int unsigned   left;
    int unsigned   right;
    int unsigned   best;
    logic          moving;
    r.status = STAT_OK;
    r.removed_key = '0;
    if (op == FUNC_INSERT) begin
      if (heap_size >= HEAP_CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        heap_size++;
        heap_keys[heap_size] = k;
        pos = heap_size;
        while (pos > 1 && heap_keys[pos] < heap_keys[pos / 2]) begin
          swap_keys(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else if (heap_size == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.removed_key = heap_keys[1];
      heap_keys[1] = heap_keys[heap_size];
      heap_size--;
      pos = 1;
      moving = 1'b1;
      // Ties between the children go to the left one; equal keys never swap.
      while (moving) begin
        left = 2 * pos;
        right = left + 1;
        best = pos;
        if (left <= heap_size && heap_keys[left] < heap_keys[best]) best = left;
        if (right <= heap_size && heap_keys[right] < heap_keys[best]) best = right;
        if (best == pos) begin
          moving = 1'b0;
        end else begin
          swap_keys(pos, best);
          pos = best;
        end
      end
    end
    r.min_key = (heap_size > 0) ? heap_keys[1] : key_t'(0);
    r.entry_count = 7'(heap_size);
    return r;
  endfunction

  always @(posedge clk_i) begin : track
    heap_outcome_t want;
    if (rst_ni) begin
      if (res_valid_i && res_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request pending: status %0d, min_key %0d",
                 status_i, min_key_i);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fails++;
          end
          if (removed_key_i !== want.removed_key) begin
            $error("removed_key: expected %0d, got %0d", want.removed_key, removed_key_i);
            fails++;
          end
          if (min_key_i !== want.min_key) begin
            $error("min_key: expected %0d, got %0d", want.min_key, min_key_i);
            fails++;
          end
          if (entry_count_i !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_i);
            fails++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = apply_request(func_e'(func_i), key_i);
        if (want.status == STAT_FULL) full_hits++;
        if (want.status == STAT_EMPTY) empty_hits++;
        outcome_q.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o <= outcome_q.size();
    checked_o <= checked;
    full_hits_o <= full_hits;
    empty_hits_o <= empty_hits;
  end

endmodule

// File: test/binary_min_heap_queue_tb.sv
// Testbench top for the binary min-heap queue: clock, reset, stimulus and verdict.
// Depends on bmhq_pkg, binary_min_heap_queue and binary_min_heap_queue_checker.
module binary_min_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int unsigned HEAP_CAPACITY = 127;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 300;
  localparam key_t        KEY_MIN = key_t'(32'h8000_0000);
  localparam key_t        KEY_MAX = key_t'(32'h7fff_ffff);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic              req_func = FUNC_INSERT;
  key_t              req_key = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  logic [1:0]        res_status;
  logic signed [31:0] res_removed_key;
  logic signed [31:0] res_min_key;
  logic [6:0]        res_entry_count;

  int   fail_count;
  int   pending;
  int   checked;
  int   full_hits;
  int   empty_hits;
  int   sent = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  binary_min_heap_queue #(
    .HEAP_CAPACITY(HEAP_CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_valid),
    .in_ready_o    (req_ready),
    .func_i        (req_func),
    .key_in_i      (req_key),
    .out_valid_o   (res_valid),
    .out_ready_i   (res_ready),
    .status_o      (res_status),
    .removed_key_o (res_removed_key),
    .min_key_o     (res_min_key),
    .entry_count_o (res_entry_count)
  );

  binary_min_heap_queue_checker #(
    .HEAP_CAPACITY(HEAP_CAPACITY)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_ready_i   (req_ready),
    .func_i        (req_func),
    .key_i         (req_key),
    .res_valid_i   (res_valid),
    .res_ready_i   (res_ready),
    .status_i      (res_status),
    .removed_key_i (res_removed_key),
    .min_key_i     (res_min_key),
    .entry_count_i (res_entry_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_hits_o   (full_hits),
    .empty_hits_o  (empty_hits)
  );

  // The receiver stalls at random, or holds off once for a long stretch on request.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(3))
      0: k = key_t'($urandom_range(8)) - key_t'(4);
      1: begin
        case ($urandom_range(3))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = '0;
          default: k = -1;
        endcase
      end
      default: k = key_t'($urandom);
    endcase
    return k;
  endfunction

  task automatic send_req(input func_e op, input key_t k);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_func <= op;
    req_key <= k;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic run_mix(input int count, input int insert_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < insert_pct) send_req(FUNC_INSERT, pick_key());
      else send_req(FUNC_DELETE, key_t'($urandom));
    end
  endtask

  task automatic wait_results_done();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Delete on an empty heap, the key extremes, equal keys and a tie between children.
    send_req(FUNC_DELETE, KEY_MAX);
    send_req(FUNC_INSERT, KEY_MIN);
    send_req(FUNC_INSERT, KEY_MAX);
    send_req(FUNC_INSERT, 0);
    send_req(FUNC_INSERT, -1);
    send_req(FUNC_INSERT, 1);
    repeat (5) send_req(FUNC_DELETE, key_t'($urandom));
    send_req(FUNC_DELETE, KEY_MIN);
    send_req(FUNC_INSERT, 0);
    send_req(FUNC_INSERT, 2);
    send_req(FUNC_INSERT, 2);
    send_req(FUNC_INSERT, 5);
    send_req(FUNC_DELETE, 0);
    send_req(FUNC_INSERT, 2);
    repeat (4) send_req(FUNC_DELETE, -1);
    wait_results_done();

    // Each mix fills the heap past capacity and then drains it past empty.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct = 37;
        end
      endcase
      run_mix(180, 90);
      run_mix(180, 10);
      wait_results_done();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    run_mix(40, 60);
    wait_results_done();

    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results under four idle mixes and a long hold-off.",
             sent, checked);
    $display("Inserts refused on a full heap: %0d; deletes on an empty heap: %0d.",
             full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_cell.sv
rtl/core/binary_min_heap_queue.sv
test/binary_min_heap_queue_checker.sv
test/binary_min_heap_queue_tb.sv
